// ----- sv/rsc_pkg.sv -----
// Shared types and constants for the rectangle subtract clip block.
package rsc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int EXT_WIDTH   = COORD_WIDTH + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int NUM_PIECES  = 4;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [EXT_WIDTH-1:0]   t_coord_ext;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUT_LEFT   = 2'd0,
        CFG_CUT_TOP    = 2'd1,
        CFG_CUT_RIGHT  = 2'd2,
        CFG_CUT_BOTTOM = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_coord src_left;
        t_coord src_top;
        t_coord src_right;
        t_coord src_bottom;
    } t_src;

    typedef struct packed {
        t_coord piece_left;
        t_coord piece_top;
        t_coord piece_right;
        t_coord piece_bottom;
        logic   piece_last;
    } t_piece;

    // One classified rectangle: source edges, clamped cut rows and the
    // inner edges of the four strips, plus which strips are non-empty.
    typedef struct packed {
        t_coord                src_left;
        t_coord                src_top;
        t_coord                src_right;
        t_coord                src_bottom;
        t_coord                cut_top;
        t_coord                cut_bottom;
        t_coord                above_bottom;
        t_coord                left_right;
        t_coord                right_left;
        t_coord                below_top;
        logic [NUM_PIECES-1:0] mask;
    } t_job;

endpackage

// ----- sv/rsc_front.sv -----
// Front end: cut registers, overlap test, clamping and strip classification.
module rsc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  rsc_pkg::t_coord            i_cfg_data,
    input  logic                       i_accept,
    input  rsc_pkg::t_src              i_src,
    output logic                       o_job_push,
    output rsc_pkg::t_job              o_job
);
    import rsc_pkg::*;

    t_coord r_cut_left, r_cut_top, r_cut_right, r_cut_bottom;

    t_coord     cl_c, cr_c, ct_c, cb_c;
    t_coord_ext sl_e, st_e, sr_e, sb_e;
    t_coord_ext left_end, right_start, above_end, below_start;
    logic       overlap;
    logic [NUM_PIECES-1:0] mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_left   <= '0;
            r_cut_top    <= '0;
            r_cut_right  <= '0;
            r_cut_bottom <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CUT_LEFT:   r_cut_left   <= i_cfg_data;
                CFG_CUT_TOP:    r_cut_top    <= i_cfg_data;
                CFG_CUT_RIGHT:  r_cut_right  <= i_cfg_data;
                CFG_CUT_BOTTOM: r_cut_bottom <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        overlap = (r_cut_left <= i_src.src_right) && (r_cut_right >= i_src.src_left) &&
                  (r_cut_top <= i_src.src_bottom) && (r_cut_bottom >= i_src.src_top);

        // clamp the cut to the rectangle
        cl_c = (i_src.src_left > r_cut_left)    ? i_src.src_left   : r_cut_left;
        cr_c = (r_cut_right > i_src.src_right)  ? i_src.src_right  : r_cut_right;
        ct_c = (r_cut_top < i_src.src_top)      ? i_src.src_top    : r_cut_top;
        cb_c = (r_cut_bottom > i_src.src_bottom) ? i_src.src_bottom : r_cut_bottom;

        sl_e = EXT_WIDTH'(i_src.src_left);
        st_e = EXT_WIDTH'(i_src.src_top);
        sr_e = EXT_WIDTH'(i_src.src_right);
        sb_e = EXT_WIDTH'(i_src.src_bottom);

        // one extra bit keeps the edge steps from wrapping
        above_end   = EXT_WIDTH'(ct_c) - EXT_WIDTH'(1);
        left_end    = EXT_WIDTH'(cl_c) - EXT_WIDTH'(1);
        right_start = EXT_WIDTH'(cr_c) + EXT_WIDTH'(1);
        below_start = EXT_WIDTH'(cb_c) + EXT_WIDTH'(1);

        mask[0] = (sl_e <= sr_e) && (st_e <= above_end);
        mask[1] = (sl_e <= left_end) && (ct_c <= cb_c);
        mask[2] = (right_start <= sr_e) && (ct_c <= cb_c);
        mask[3] = (sl_e <= sr_e) && (below_start <= sb_e);

        o_job.src_left     = i_src.src_left;
        o_job.src_top      = i_src.src_top;
        o_job.src_right    = i_src.src_right;
        o_job.src_bottom   = i_src.src_bottom;
        o_job.cut_top      = ct_c;
        o_job.cut_bottom   = cb_c;
        o_job.left_right   = left_end[COORD_WIDTH-1:0];
        o_job.right_left   = right_start[COORD_WIDTH-1:0];
        o_job.below_top    = below_start[COORD_WIDTH-1:0];
        if (overlap) begin
            o_job.above_bottom = above_end[COORD_WIDTH-1:0];
            o_job.mask         = mask;
        end else begin
            // pass the rectangle through whole as the first strip
            o_job.above_bottom = i_src.src_bottom;
            o_job.mask         = NUM_PIECES'(1);
        end

        // a rectangle covered by the cut produces nothing
        o_job_push = i_accept && (o_job.mask != '0);
    end

    ap_push_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> (o_job.mask != '0))
        else $error("job pushed with no strips");

    ap_miss_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !overlap) |-> (o_job_push && o_job.mask == NUM_PIECES'(1)))
        else $error("non-overlapping rectangle not passed through");

    ap_cover_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && overlap && mask == '0) |-> !o_job_push)
        else $error("covered rectangle produced a job");

endmodule

// ----- sv/rsc_fifo.sv -----
// Short job queue between the front end and the piece emitter.
module rsc_fifo #(
    parameter int DEPTH = rsc_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rsc_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output rsc_pkg::t_job o_data,
    output logic          o_empty
);
    import rsc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    ap_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    ap_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

// ----- sv/rsc_back.sv -----
// Back end: walks job strips, one piece per cycle unless output stalls.
module rsc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rsc_pkg::t_job   i_job,
    input  logic            i_job_empty,
    output logic            o_job_pop,
    output rsc_pkg::t_piece o_piece,
    output logic            o_empty,
    input  logic            i_pop
);
    import rsc_pkg::*;

    logic                  r_busy;
    t_job                  r_job;
    logic [NUM_PIECES-1:0] r_mask;
    logic                  r_out_valid;
    t_piece                r_out;

    logic                  out_rdy, emit, load, done;
    logic [NUM_PIECES-1:0] sel, rem;
    t_piece                piece;

    always_comb begin
        sel  = r_mask & (~r_mask + NUM_PIECES'(1));
        rem  = r_mask & ~sel;
        done = (rem == '0);

        piece.piece_left   = r_job.src_left;
        piece.piece_top    = r_job.src_top;
        piece.piece_right  = r_job.src_right;
        piece.piece_bottom = r_job.src_bottom;
        piece.piece_last   = done;
        priority if (r_mask[0]) begin
            piece.piece_bottom = r_job.above_bottom;
        end else if (r_mask[1]) begin
            piece.piece_top    = r_job.cut_top;
            piece.piece_right  = r_job.left_right;
            piece.piece_bottom = r_job.cut_bottom;
        end else if (r_mask[2]) begin
            piece.piece_left   = r_job.right_left;
            piece.piece_top    = r_job.cut_top;
            piece.piece_bottom = r_job.cut_bottom;
        end else begin
            piece.piece_top    = r_job.below_top;
        end

        out_rdy   = !r_out_valid || i_pop;
        emit      = r_busy && out_rdy;
        // fetch the next job when idle or on the current one's last piece
        load      = !i_job_empty && (!r_busy || (emit && done));
        o_job_pop = load;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out <= piece;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_mask <= i_job.mask;
            end else if (emit) begin
                r_busy <= !done;
                r_mask <= rem;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_piece = r_out;
    assign o_empty = !r_out_valid;

    ap_busy_has_strip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != '0))
        else $error("emitter busy with no strips left");

    ap_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting piece lost or changed");

    ap_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (!r_busy || (emit && done)))
        else $error("job fetched while strips remain");

endmodule

// ----- sv/rectangle_subtract_clip_top.sv -----
// Top level of the rectangle subtract clip block.
// Removes the configured cut rectangle from each incoming rectangle and
// returns the remaining strips in the order above, left, right, below, with
// piece_last set on the final one; a rectangle missing the cut comes back
// unchanged and one wholly inside the cut gives nothing. The front end
// takes one rectangle per cycle while its job queue has room; the back end
// hands out one piece per cycle through a single output register while
// that register is free or popped; a rectangle gives one to four pieces.
// The first piece passes the job queue, job register and output register.
// The user must write the cut registers through the config port only
// while the block is idle; the block itself does not enforce this.
module rectangle_subtract_clip_top #(
    parameter int QUEUE_DEPTH = rsc_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  rsc_pkg::t_coord               i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  rsc_pkg::t_src                 i_src,
    output logic                          empty,
    input  logic                          pop,
    output rsc_pkg::t_piece               o_piece
);
    import rsc_pkg::*;

    logic job_push, job_full, job_pop, job_empty;
    t_job job_in, job_out;

    rsc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (push && !job_full),
        .i_src      (i_src),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    rsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    rsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_piece     (o_piece),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign full = job_full;

endmodule
